// ----- sv/sigma_filter_window_unit_macros.svh -----
// Assertion macros used by the sigma filter window checker.
`ifndef SIGMA_FILTER_WINDOW_UNIT_MACROS_SVH
`define SIGMA_FILTER_WINDOW_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low
`define SFW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sigma filter window check failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low
`define SFW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sigma filter window check failed");

`endif

// ----- sv/sfw_pkg.sv -----
// Shared constants and types of the sigma filter window unit.
package sfw_pkg;

    localparam int RADIUS      = 2;
    localparam int SIDE        = 2 * RADIUS + 1;
    localparam int LINES       = 2 * RADIUS;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 12;
    localparam int CFG_W       = 13;
    localparam int TOL_W       = 9;
    localparam int CIDX_W      = 2;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W       = $clog2(MAX_HEIGHT + 1);
    localparam int SUM_W       = $clog2(SIDE * SIDE * 255 + 1);
    localparam int CNT_W       = $clog2(SIDE * SIDE + 1);
    localparam int COL_W       = $clog2(SIDE);
    localparam int STEP_W      = $clog2(SUM_W);
    localparam int OUT_W       = PIX_W + 2 * COORD_W;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int TOL_RESET    = 20;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_TOLERANCE    = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;

    // Access control shared by every line cell of the chain
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
    } cell_ctrl_t;

endpackage

// ----- sv/sfw_line_cell.sv -----
// One line cell: a column-addressed line memory that hands its old pixel to the next cell.
module sfw_line_cell (
    input  logic                aclk,
    input  sfw_pkg::cell_ctrl_t ctrl,
    input  sfw_pkg::pix_t       wr_data,
    output sfw_pkg::pix_t       rd_data
);
    import sfw_pkg::*;

    pix_t mem [MAX_WIDTH];
    pix_t rd_data_reg;

    // Write the incoming pixel, read the stored one with a registered port
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/sfw_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the window mean.
module sfw_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sfw_pkg::SUM_W-1:0]  dividend,
    input  logic [sfw_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [sfw_pkg::SUM_W-1:0]  quotient
);
    import sfw_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W:0]    trial;
    logic              fits;
    logic [CNT_W-1:0]  rem_next;

    // Shift in the next dividend bit and try to subtract
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign fits     = trial >= {1'b0, div_reg};
    assign rem_next = fits ? CNT_W'(trial - {1'b0, div_reg}) : CNT_W'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            step_reg <= STEP_W'(SUM_W - 1);
        end else if (busy_reg) begin
            quo_reg  <= {quo_reg[SUM_W-2:0], fits};
            rem_reg  <= rem_next;
            step_reg <= step_reg - 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/sigma_filter_window_unit.sv -----
// Top level of the streaming sigma filter window unit.
// Pixels enter in raster order, one item at a time: an item is taken, the chain of
// 2*RADIUS line cells is read at its column and then written with the shifted column,
// the window is scanned one column per cycle and the mean comes from a bit-serial
// divider. A border pixel passes only through the fetch state; an interior pixel then
// goes on to the column scan, the 13-step divider and the output state, which
// waits for the previous result to be taken from the output register. Results carry
// the center column and row; tlast marks the last interior result of a frame.
module sigma_filter_window_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sfw_pkg::PIX_W-1:0]   s_tdata,   // [7:0] pixel
    input  logic                        s_tuser,   // frame_start
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sfw_pkg::OUT_W-1:0]   m_tdata,   // [7:0] filtered, [19:8] out_x, [31:20] out_y
    output logic                        m_tlast,   // last_of_frame
    input  logic                        cfg_wr_en,
    input  logic [sfw_pkg::CIDX_W-1:0]  cfg_wr_index,
    input  logic [sfw_pkg::CFG_W-1:0]   cfg_wr_data
);
    import sfw_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [WID_W-1:0]   eff_w;
    logic [HGT_W-1:0]   eff_h;
    logic [TOL_W-1:0]   eff_tol;

    logic [ADDR_W-1:0]  col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [ADDR_W-1:0]  col_base, cur_x, col_next;
    logic [COORD_W-1:0] row_base, row_next;
    logic [WID_W-1:0]   x_inc;
    logic               wrap, accept, has_result, is_last;

    logic [ADDR_W-1:0]  x_reg;
    logic [COORD_W-1:0] y_reg;
    pix_t               pix_reg;
    logic               has_reg, last_reg;

    cell_ctrl_t         cell_ctrl;
    pix_t               cell_in  [LINES];
    pix_t               cell_out [LINES];
    pix_t               win_reg  [SIDE][SIDE];

    logic [COL_W-1:0]   acc_col_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   col_sum;
    logic [CNT_W-1:0]   col_cnt;
    pix_t               center;
    logic               acc_last, div_start, div_done;
    logic [SUM_W-1:0]   quotient;

    logic               m_tvalid_reg, m_tlast_reg;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic               out_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(WIDTH_RESET);
            height_reg <= CFG_W'(HEIGHT_RESET);
            tol_reg    <= TOL_W'(TOL_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                REG_TOLERANCE:    tol_reg    <= cfg_wr_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the settings to their usable ranges
    always_comb begin
        if (width_reg == '0) begin
            eff_w = WID_W'(1);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = HGT_W'(1);
        end else if (int'(height_reg) > MAX_HEIGHT) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = HGT_W'(height_reg);
        end
        eff_tol = (tol_reg == '0) ? TOL_W'(1) : tol_reg;
    end

    // Position of the arriving pixel and the counters after it
    assign accept     = s_tvalid && s_tready;
    assign col_base   = s_tuser ? '0 : col_reg;
    assign row_base   = s_tuser ? '0 : row_reg;
    assign cur_x      = (WID_W'(col_base) >= eff_w) ? '0 : col_base;
    assign x_inc      = WID_W'(cur_x) + 1'b1;
    assign wrap       = x_inc >= eff_w;
    assign col_next   = wrap ? '0 : ADDR_W'(x_inc);
    assign row_next   = wrap ? row_base + 1'b1 : row_base;
    assign has_result = (int'(cur_x) >= LINES) && (int'(row_base) >= LINES)
                        && (HGT_W'(row_base) < eff_h);
    assign is_last    = (WID_W'(cur_x) == eff_w - 1'b1) && (HGT_W'(row_base) == eff_h - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Hold the item while it is worked on
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= cur_x;
            y_reg    <= row_base;
            pix_reg  <= s_tdata;
            has_reg  <= has_result;
            last_reg <= is_last;
        end
    end

    // Chain of line cells: read at accept, write the shifted column in the following cycle
    assign cell_ctrl.rd_en   = accept;
    assign cell_ctrl.rd_addr = cur_x;
    assign cell_ctrl.wr_en   = (state_reg == ST_FETCH);
    assign cell_ctrl.wr_addr = x_reg;
    assign cell_in[0]        = pix_reg;

    for (genvar k = 0; k < LINES; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign cell_in[k] = cell_out[k-1];
        end
        sfw_line_cell u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl),
            .wr_data (cell_in[k]),
            .rd_data (cell_out[k])
        );
    end

    // Advance the window by one column; row 0 is the newest line
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            for (int r = 0; r < SIDE; r++) begin
                for (int c = SIDE - 1; c > 0; c--) begin
                    win_reg[r][c] <= win_reg[r][c-1];
                end
            end
            win_reg[0][0] <= pix_reg;
            for (int r = 1; r < SIDE; r++) begin
                win_reg[r][0] <= cell_out[r-1];
            end
        end
    end

    // Count and sum the pixels of one window column that lie within tolerance
    assign center = win_reg[RADIUS][RADIUS];

    always_comb begin
        pix_t p;
        pix_t d;
        col_sum = '0;
        col_cnt = '0;
        for (int r = 0; r < SIDE; r++) begin
            p = win_reg[r][acc_col_reg];
            d = (p >= center) ? p - center : center - p;
            if (TOL_W'(d) < eff_tol) begin
                col_sum = col_sum + SUM_W'(p);
                col_cnt = col_cnt + 1'b1;
            end
        end
    end

    assign sum_next  = sum_reg + col_sum;
    assign cnt_next  = cnt_reg + col_cnt;
    assign acc_last  = (acc_col_reg == COL_W'(SIDE - 1));
    assign div_start = (state_reg == ST_ACC) && acc_last;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            acc_col_reg <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
        end else if (state_reg == ST_ACC) begin
            acc_col_reg <= acc_col_reg + 1'b1;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
        end
    end

    sfw_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (cnt_next),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sequencer
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_FETCH;
            ST_FETCH: state_next = has_reg ? ST_ACC : ST_IDLE;
            ST_ACC:   if (acc_last) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Output register: load the result, drop valid once it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {y_reg - COORD_W'(RADIUS),
                            COORD_W'(x_reg - ADDR_W'(RADIUS)),
                            quotient[PIX_W-1:0]};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tvalid_reg && m_tlast_reg;

endmodule

// ----- sv/sfw_checker.sv -----
// Port-level checker of the sigma filter window unit, bound to the top level.
`include "sigma_filter_window_unit_macros.svh"

module sfw_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [sfw_pkg::OUT_W-1:0]  m_tdata,
    input logic                       m_tlast
);
    import sfw_pkg::*;

    // A stalled result keeps its payload
    `SFW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Items are worked on one at a time
    `SFW_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

    // Every result center lies at least RADIUS inside the frame
    `SFW_ASSERT_NOW(a_center_inside, m_tvalid, (m_tdata[19:8] >= COORD_W'(RADIUS)) && (m_tdata[31:20] >= COORD_W'(RADIUS)))

    // The frame end mark comes only with a result
    `SFW_ASSERT_NOW(a_last_valid, m_tlast, m_tvalid)

endmodule

bind sigma_filter_window_unit sfw_checker u_sfw_checker (.*);
